>>> design/nwom_pkg.sv
// shared constants and calendar tables for the nth weekday of month block
`default_nettype none
package nwom_pkg;

	localparam int unsigned YEAR_W  = 14;
	localparam int unsigned MONTH_W = 4;
	localparam int unsigned SEL_W   = 3;
	localparam int unsigned WD_W    = 3;
	localparam int unsigned DAY_W   = 5;
	localparam int unsigned YY_W    = 15;
	localparam int unsigned SUM_W   = 15;

	localparam logic [YY_W-1:0]    YEAR_OFFSET  = 15'd400;
	localparam logic [MONTH_W-1:0] MONTH_JAN    = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR    = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_DEC    = 4'd12;
	localparam logic [WD_W-1:0]    WD_INVALID   = 3'd7;
	localparam logic [SEL_W-1:0]   SEL_FIFTH    = 3'd4;
	localparam logic [SEL_W-1:0]   SEL_TEENTH   = 3'd5;
	localparam logic [SEL_W-1:0]   SEL_LAST     = 3'd6;
	localparam logic [SEL_W-1:0]   SEL_INVALID  = 3'd7;
	localparam logic [DAY_W-1:0]   FIRST_DAY    = 5'd1;
	localparam logic [DAY_W-1:0]   TEENTH_FIRST = 5'd13;
	localparam logic [DAY_W-1:0]   TEENTH_LAST  = 5'd19;
	localparam logic [DAY_W-1:0]   LAST_MIN     = 5'd22;
	localparam logic [3:0]         WEEK_LEN     = 4'd7;

	// floor(x/25) = (x * RECIP25) >> 17 for x below 43690
	localparam logic [12:0]        RECIP25      = 13'd5243;
	// floor(x/7) = (x * RECIP7) >> 17 for x below 43690
	localparam logic [SUM_W-1:0]   RECIP7       = 15'd18725;
	localparam int unsigned        RECIP_SHIFT  = 17;

	function automatic logic [2:0] month_shift(input logic [MONTH_W-1:0] m);
		logic [2:0] s;
		case (m)
			4'd1:    s = 3'd0;
			4'd2:    s = 3'd3;
			4'd3:    s = 3'd2;
			4'd4:    s = 3'd5;
			4'd5:    s = 3'd0;
			4'd6:    s = 3'd3;
			4'd7:    s = 3'd5;
			4'd8:    s = 3'd1;
			4'd9:    s = 3'd4;
			4'd10:   s = 3'd6;
			4'd11:   s = 3'd2;
			4'd12:   s = 3'd4;
			default: s = 3'd0;
		endcase
		return s;
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] l;
		case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: l = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                    l = 5'd30;
			4'd2:    l = leap ? 5'd29 : 5'd28;
			default: l = 5'd0;
		endcase
		return l;
	endfunction

endpackage
`default_nettype wire

>>> design/nth_weekday_of_month.sv
// Finds the day of the month on which the nth, teenth or last given weekday of a Gregorian
// month falls; day is 0 when that date does not exist or when month, weekday or week selector
// is out of range. Four-stage pipeline (input register, century terms, weekday sum, result
// register): out_valid rises when a word reaches the result register; one word can be
// accepted every cycle unless out_ready stalls a full pipeline. Each stage advances on its own,
// so bubbles close up and the input keeps taking words while a result waits at the output.
`default_nettype none
module nth_weekday_of_month (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [nwom_pkg::YEAR_W-1:0]   year,
	input  wire logic [nwom_pkg::MONTH_W-1:0]  month,
	input  wire logic [nwom_pkg::SEL_W-1:0]    which_week,
	input  wire logic [nwom_pkg::WD_W-1:0]     weekday,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [nwom_pkg::DAY_W-1:0]         day
);

	// pipeline control
	logic v_s1, v_s2, v_s3, v_s4;
	logic en1, en2, en3, en4;

	assign en4      = !v_s4 || out_ready;
	assign en3      = !v_s3 || en4;
	assign en2      = !v_s2 || en3;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
			if (en3) v_s3 <= v_s2;
			if (en4) v_s4 <= v_s3;
		end
	end

	// stage 1: input register
	logic [nwom_pkg::YEAR_W-1:0]  year_s1;
	logic [nwom_pkg::MONTH_W-1:0] month_s1;
	logic [nwom_pkg::SEL_W-1:0]   sel_s1;
	logic [nwom_pkg::WD_W-1:0]    wd_s1;

	always_ff @(posedge clk) begin
		if (en1) begin
			year_s1  <= year;
			month_s1 <= month;
			sel_s1   <= which_week;
			wd_s1    <= weekday;
		end
	end

	// stage 2: shifted year and its century count
	logic [nwom_pkg::YY_W-1:0] yy_a;
	logic [12:0]               q4_a;
	logic [25:0]               prod25_a;
	logic                      bad_a;

	assign yy_a = nwom_pkg::YY_W'(year_s1) + nwom_pkg::YEAR_OFFSET
		- ((month_s1 < nwom_pkg::MONTH_MAR) ? 15'd1 : 15'd0);
	assign q4_a     = yy_a[14:2];
	assign prod25_a = 26'(q4_a) * 26'(nwom_pkg::RECIP25);
	assign bad_a    = (month_s1 < nwom_pkg::MONTH_JAN) || (month_s1 > nwom_pkg::MONTH_DEC)
		|| (wd_s1 == nwom_pkg::WD_INVALID) || (sel_s1 == nwom_pkg::SEL_INVALID);

	logic [nwom_pkg::YY_W-1:0]    yy_s2;
	logic [7:0]                   q100_s2;
	logic [nwom_pkg::MONTH_W-1:0] month_s2;
	logic [nwom_pkg::SEL_W-1:0]   sel_s2;
	logic [nwom_pkg::WD_W-1:0]    wd_s2;
	logic                         bad_s2;

	always_ff @(posedge clk) begin
		if (en2) begin
			yy_s2    <= yy_a;
			q100_s2  <= prod25_a[nwom_pkg::RECIP_SHIFT +: 8];
			month_s2 <= month_s1;
			sel_s2   <= sel_s1;
			wd_s2    <= wd_s1;
			bad_s2   <= bad_a;
		end
	end

	// stage 3: leap test, month length and weekday sum
	logic [nwom_pkg::YY_W-1:0]  c100_b;
	logic                       leap_b;
	logic [nwom_pkg::DAY_W-1:0] len_b;
	logic [nwom_pkg::DAY_W-1:0] dref_b;
	logic [nwom_pkg::SUM_W-1:0] sum_b;

	// yy equals year + 399 in february, so the year is a leap year when yy + 1 is one
	assign c100_b = (nwom_pkg::YY_W'(q100_s2) << 6) + (nwom_pkg::YY_W'(q100_s2) << 5)
		+ (nwom_pkg::YY_W'(q100_s2) << 2);
	assign leap_b = (yy_s2[1:0] == 2'b11)
		&& ((yy_s2 != c100_b + 15'd99) || (q100_s2[1:0] == 2'b11));
	assign len_b  = nwom_pkg::month_len(month_s2, leap_b);

	always_comb begin
		if (sel_s2 <= nwom_pkg::SEL_FIFTH)
			dref_b = nwom_pkg::FIRST_DAY;
		else if (sel_s2 == nwom_pkg::SEL_TEENTH)
			dref_b = nwom_pkg::TEENTH_FIRST;
		else
			dref_b = len_b;
	end

	assign sum_b = yy_s2 + nwom_pkg::SUM_W'(yy_s2[14:2]) - nwom_pkg::SUM_W'(q100_s2)
		+ nwom_pkg::SUM_W'(q100_s2[7:2]) + nwom_pkg::SUM_W'(nwom_pkg::month_shift(month_s2))
		+ nwom_pkg::SUM_W'(dref_b);

	logic [nwom_pkg::SUM_W-1:0] sum_s3;
	logic [nwom_pkg::DAY_W-1:0] len_s3;
	logic [nwom_pkg::SEL_W-1:0] sel_s3;
	logic [nwom_pkg::WD_W-1:0]  wd_s3;
	logic                       bad_s3;

	always_ff @(posedge clk) begin
		if (en3) begin
			sum_s3 <= sum_b;
			len_s3 <= len_b;
			sel_s3 <= sel_s2;
			wd_s3  <= wd_s2;
			bad_s3 <= bad_s2;
		end
	end

	// stage 4: weekday of the reference day and the result
	logic [29:0]                prod7_c;
	logic [12:0]                q7_c;
	logic [nwom_pkg::SUM_W-1:0] r7_c;
	logic [2:0]                 dow_c;
	logic [3:0]                 fwd_c, back_c;
	logic [2:0]                 fwd7_c, back7_c;
	logic [5:0]                 nth_c;
	logic [nwom_pkg::DAY_W-1:0] day_c;

	assign prod7_c = 30'(sum_s3) * 30'(nwom_pkg::RECIP7);
	assign q7_c    = prod7_c[nwom_pkg::RECIP_SHIFT +: 13];
	assign r7_c    = sum_s3 - ((nwom_pkg::SUM_W'(q7_c) << 3) - nwom_pkg::SUM_W'(q7_c));
	assign dow_c   = r7_c[2:0];

	assign fwd_c   = 4'(wd_s3) + nwom_pkg::WEEK_LEN - 4'(dow_c);
	assign back_c  = 4'(dow_c) + nwom_pkg::WEEK_LEN - 4'(wd_s3);
	assign fwd7_c  = (fwd_c >= nwom_pkg::WEEK_LEN) ? 3'(fwd_c - nwom_pkg::WEEK_LEN) : fwd_c[2:0];
	assign back7_c = (back_c >= nwom_pkg::WEEK_LEN) ? 3'(back_c - nwom_pkg::WEEK_LEN)
		: back_c[2:0];
	assign nth_c   = 6'd1 + 6'(fwd7_c) + 6'(sel_s3) * 6'(nwom_pkg::WEEK_LEN);

	always_comb begin
		if (bad_s3)
			day_c = '0;
		else if (sel_s3 inside {[3'd0:nwom_pkg::SEL_FIFTH]})
			day_c = (nth_c <= 6'(len_s3)) ? nth_c[4:0] : '0;
		else if (sel_s3 == nwom_pkg::SEL_TEENTH)
			day_c = nwom_pkg::TEENTH_FIRST + nwom_pkg::DAY_W'(fwd7_c);
		else
			day_c = len_s3 - nwom_pkg::DAY_W'(back7_c);
	end

	logic [nwom_pkg::DAY_W-1:0] day_s4;

	always_ff @(posedge clk) begin
		if (en4)
			day_s4 <= day_c;
	end

	assign out_valid = v_s4;
	assign day       = day_s4;

`ifndef SYNTHESIS
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!v_s4 |-> in_ready)
		else $error("input stalled with an empty output register");

	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en4 && bad_s3 |=> day == '0)
		else $error("out of range word gave a nonzero day");

	a_teenth: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en4 && !bad_s3 && sel_s3 == nwom_pkg::SEL_TEENTH
		|=> day >= nwom_pkg::TEENTH_FIRST && day <= nwom_pkg::TEENTH_LAST)
		else $error("teenth day outside 13 to 19");

	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && en4 && !bad_s3 && sel_s3 == nwom_pkg::SEL_LAST
		|=> day >= nwom_pkg::LAST_MIN)
		else $error("last occurrence too early in the month");
`endif

endmodule
`default_nettype wire

>>> tb/nwom_day_checker.sv
// checker for the nth weekday of month block: predicts each day and compares the results
module nwom_day_checker
	import nwom_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic [YEAR_W-1:0]  year,
	input  wire logic [MONTH_W-1:0] month,
	input  wire logic [SEL_W-1:0]   which_week,
	input  wire logic [WD_W-1:0]    weekday,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [DAY_W-1:0]   day,
	output int                      mismatches,
	output int                      outstanding,
	output int                      days_checked,
	output int                      absent_days
);

	localparam int unsigned DAYS_PER_WEEK = 7;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic [YEAR_W-1:0]  year;
		logic [MONTH_W-1:0] month;
		logic [SEL_W-1:0]   sel;
		logic [WD_W-1:0]    wd;
		logic [DAY_W-1:0]   day;
	} day_query_t;

	day_query_t expected_days[$];
	int fail_cnt = 0;
	int checked_cnt = 0;
	int absent_cnt = 0;

	function automatic int unsigned month_offset(input int unsigned m);
		int unsigned off;
		case (m)
			1, 5:    off = 0;
			2, 6:    off = 3;
			3, 11:   off = 2;
			4, 7:    off = 5;
			8:       off = 1;
			9, 12:   off = 4;
			default: off = 6;
		endcase
		return off;
	endfunction

	function automatic int unsigned days_in_month(input int unsigned y, input int unsigned m);
		int unsigned len;
		bit leap;
		leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
		case (m)
			4, 6, 9, 11: len = 30;
			MONTH_FEB:   len = leap ? 29 : 28;
			default:     len = 31;
		endcase
		return len;
	endfunction

	// weekday of a date, sunday is 0; the 400-year shift keeps the year positive
	function automatic int unsigned weekday_on(input int unsigned y, input int unsigned m,
			input int unsigned d);
		int unsigned yy;
		yy = y + 400;
		if (m < MONTH_MAR)
			yy = yy - 1;
		return (yy + yy / 4 - yy / 100 + yy / 400 + month_offset(m) + d) % DAYS_PER_WEEK;
	endfunction

	function automatic logic [DAY_W-1:0] calc_day(input logic [YEAR_W-1:0] y,
			input logic [MONTH_W-1:0] m, input logic [SEL_W-1:0] s, input logic [WD_W-1:0] w);
		int unsigned len, dow, d;
		if (m < MONTH_JAN || m > MONTH_DEC || w == WD_INVALID || s == SEL_INVALID)
			return '0;
		len = days_in_month(32'(y), 32'(m));
		if (s <= SEL_FIFTH) begin
			dow = weekday_on(32'(y), 32'(m), 1);
			d = 1 + (w + DAYS_PER_WEEK - dow) % DAYS_PER_WEEK + DAYS_PER_WEEK * s;
			if (d > len)
				d = 0;
		end else if (s == SEL_TEENTH) begin
			dow = weekday_on(32'(y), 32'(m), 32'(TEENTH_FIRST));
			d = TEENTH_FIRST + (w + DAYS_PER_WEEK - dow) % DAYS_PER_WEEK;
		end else begin
			dow = weekday_on(32'(y), 32'(m), len);
			d = len - (dow + DAYS_PER_WEEK - w) % DAYS_PER_WEEK;
		end
		return DAY_W'(d);
	endfunction

	always @(posedge clk) begin
		day_query_t q;
		day_query_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_days.size() == 0) begin
					fail_cnt++;
					if (fail_cnt <= REPORT_LIMIT)
						$display("unexpected day %0d with no query pending", day);
				end else begin
					want = expected_days.pop_front();
					checked_cnt++;
					if (want.day == 0)
						absent_cnt++;
					if (day !== want.day) begin
						fail_cnt++;
						if (fail_cnt <= REPORT_LIMIT)
							$display("mismatch: y %0d m %0d week %0d wd %0d exp %0d got %0d",
								want.year, want.month, want.sel, want.wd, want.day, day);
					end
				end
			end
			if (in_valid && in_ready) begin
				q.year = year;
				q.month = month;
				q.sel = which_week;
				q.wd = weekday;
				q.day = calc_day(year, month, which_week, weekday);
				expected_days.push_back(q);
			end
			mismatches <= fail_cnt;
			outstanding <= expected_days.size();
			days_checked <= checked_cnt;
			absent_days <= absent_cnt;
		end
	end

endmodule

>>> tb/testbench.sv
// top of the nth weekday of month testbench: clock, reset, stimulus, receiver and verdict
module testbench;
	import nwom_pkg::*;

	localparam int RANDOM_WORDS = 1800;
	localparam int DRAIN_AT = 900;
	localparam int HOLD_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int SETTLE_CYCLES = 12;

	localparam logic [SEL_W-1:0] SEL_FIRST  = 3'd0;
	localparam logic [SEL_W-1:0] SEL_SECOND = 3'd1;
	localparam logic [SEL_W-1:0] SEL_THIRD  = 3'd2;
	localparam logic [SEL_W-1:0] SEL_FOURTH = 3'd3;

	localparam logic [WD_W-1:0] SUNDAY    = 3'd0;
	localparam logic [WD_W-1:0] MONDAY    = 3'd1;
	localparam logic [WD_W-1:0] TUESDAY   = 3'd2;
	localparam logic [WD_W-1:0] WEDNESDAY = 3'd3;
	localparam logic [WD_W-1:0] THURSDAY  = 3'd4;
	localparam logic [WD_W-1:0] FRIDAY    = 3'd5;
	localparam logic [WD_W-1:0] SATURDAY  = 3'd6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [YEAR_W-1:0] year = '0;
	logic [MONTH_W-1:0] month = '0;
	logic [SEL_W-1:0] which_week = '0;
	logic [WD_W-1:0] weekday = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [DAY_W-1:0] day;

	int day_faults;
	int days_pending;
	int days_checked;
	int absent_days;
	int odd_fields = 0;
	int words_sent = 0;
	int burst_left = 0;
	int idle_cycles = 0;

	nth_weekday_of_month u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.year       (year),
		.month      (month),
		.which_week (which_week),
		.weekday    (weekday),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.day        (day)
	);

	nwom_day_checker u_day_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.year         (year),
		.month        (month),
		.which_week   (which_week),
		.weekday      (weekday),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.day          (day),
		.mismatches   (day_faults),
		.outstanding  (days_pending),
		.days_checked (days_checked),
		.absent_days  (absent_days)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic send_word(input logic [YEAR_W-1:0] y, input logic [MONTH_W-1:0] m,
			input logic [SEL_W-1:0] s, input logic [WD_W-1:0] w);
		in_valid <= 1'b1;
		year <= y;
		month <= m;
		which_week <= s;
		weekday <= w;
		if (m < MONTH_JAN || m > MONTH_DEC || s == SEL_INVALID || w == WD_INVALID)
			odd_fields++;
		words_sent++;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic pace_sender();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		do @(posedge clk); while (days_pending != 0);
	endtask

	task automatic send_random_word();
		logic [YEAR_W-1:0] y;
		logic [MONTH_W-1:0] m;
		logic [SEL_W-1:0] s;
		logic [WD_W-1:0] w;
		case ($urandom_range(0, 9))
			0:       y = YEAR_W'($urandom_range(0, 16383));
			1:       y = YEAR_W'($urandom_range(0, 163) * 100);
			2:       y = YEAR_W'($urandom_range(0, 40));
			default: y = YEAR_W'($urandom_range(1, 9999));
		endcase
		case ($urandom_range(0, 9))
			0:       m = MONTH_W'($urandom_range(0, 15));
			1, 2:    m = MONTH_FEB;
			default: m = MONTH_W'($urandom_range(1, 12));
		endcase
		s = ($urandom_range(0, 15) == 0) ? SEL_W'($urandom_range(0, 7))
			: SEL_W'($urandom_range(0, 6));
		w = ($urandom_range(0, 15) == 0) ? WD_W'($urandom_range(0, 7))
			: WD_W'($urandom_range(0, 6));
		send_word(y, m, s, w);
	endtask

	// receiver: random ready pattern with two long hold-offs while words keep coming
	initial begin
		int mode_left;
		int ready_pct;
		int holds_done;
		int next_hold;
		mode_left = 0;
		ready_pct = 100;
		holds_done = 0;
		next_hold = 400;
		forever begin
			@(posedge clk);
			if (arst_n && holds_done < 2 && days_checked >= next_hold) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
				next_hold = 1300;
			end else begin
				if (mode_left == 0) begin
					mode_left = $urandom_range(16, 96);
					case ($urandom_range(0, 3))
						0:       ready_pct = 100;
						1:       ready_pct = 75;
						2:       ready_pct = 40;
						default: ready_pct = 10;
					endcase
				end
				mode_left--;
				out_ready <= ($urandom_range(1, 100) <= ready_pct);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no word moved for %0d cycles", idle_cycles);
			$display("testbench NOT OK");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed corners, back to back
		send_word(14'd1, MONTH_JAN, SEL_FIRST, SUNDAY);
		send_word(14'd9999, MONTH_DEC, SEL_LAST, SATURDAY);
		send_word(14'd0, MONTH_FEB, SEL_LAST, MONDAY);
		send_word(14'd16383, MONTH_FEB, SEL_LAST, TUESDAY);
		send_word(14'd2000, MONTH_FEB, SEL_FIFTH, TUESDAY);
		send_word(14'd1900, MONTH_FEB, SEL_LAST, WEDNESDAY);
		send_word(14'd2024, MONTH_FEB, SEL_FIFTH, THURSDAY);
		send_word(14'd2023, MONTH_FEB, SEL_FIFTH, FRIDAY);
		send_word(14'd2013, 4'd5, SEL_TEENTH, MONDAY);
		send_word(14'd2019, 4'd4, SEL_TEENTH, SATURDAY);
		send_word(14'd2021, 4'd8, SEL_SECOND, SUNDAY);
		send_word(14'd1582, 4'd10, SEL_THIRD, THURSDAY);
		send_word(14'd2100, MONTH_DEC, SEL_FOURTH, FRIDAY);
		send_word(14'd2020, MONTH_JAN, SEL_FIFTH, SATURDAY);
		send_word(14'd2020, 4'd0, SEL_FIRST, MONDAY);
		send_word(14'd2020, 4'd13, SEL_LAST, MONDAY);
		send_word(14'd2020, 4'd15, SEL_TEENTH, MONDAY);
		send_word(14'd2020, 4'd6, SEL_FIRST, WD_INVALID);
		send_word(14'd2020, 4'd6, SEL_INVALID, SUNDAY);
		send_word(14'd16383, 4'd15, SEL_INVALID, WD_INVALID);
		send_word(14'd0, 4'd0, SEL_FIRST, SUNDAY);
		drain();

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i == DRAIN_AT)
				drain();
			pace_sender();
			send_random_word();
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("sent %0d queries, %0d with bad fields; checked %0d days, %0d of them 0",
			words_sent, odd_fields, days_checked, absent_days);
		$display("sender bursts and a full drain, receiver random stalls and two long hold-offs");
		if (day_faults == 0 && days_pending == 0)
			$display("testbench OK");
		else
			$display("testbench NOT OK");
		$finish;
	end

endmodule
